// File: hw/rtl/gcd_pkg.sv
// Shared types, fixed-point constants and the CORDIC angle table for the distance pipeline.
package gcd_pkg;

    localparam int ITERATIONS_DEF = 24;
    localparam int SQRT_STEPS     = 31;
    localparam int CONV_STAGES    = 3;

    typedef logic signed [33:0] cxy_t;
    typedef logic signed [32:0] cz_t;
    typedef logic [61:0]        sq_t;
    typedef logic [29:0]        deg_t;
    typedef logic [30:0]        rad_t;

    localparam cxy_t             CORDIC_GAIN   = 34'sd652032874;
    localparam rad_t             HALF_PI       = 31'd1686629713;
    localparam rad_t             ONE_Q30       = 31'd1073741824;
    localparam logic signed [32:0] HALF_TURN   = 33'sd754974720;
    localparam logic signed [32:0] FULL_TURN   = 33'sd1509949440;
    localparam logic signed [32:0] QUARTER_TURN = 33'sd377487360;
    localparam logic [22:0]      MAX_DISTANCE  = 23'd6587592;
    localparam logic [12:0]      RADIUS_RESET  = 13'd6371;
    localparam logic [24:0]      PI_DIV_180    = 25'd18740330;
    localparam logic [26:0]      RECIP_45      = 27'd95443717;

    // atan(2^-i) in Q30, rounded; small angles collapse to 2^-i
    function automatic cz_t atan_q30(input int stage);
        cz_t v;
        v = '0;
        unique case (stage)
            0: v = 33'sd843314856;
            1: v = 33'sd497837829;
            2: v = 33'sd263043837;
            3: v = 33'sd133525159;
            4: v = 33'sd67021687;
            5: v = 33'sd33543516;
            6: v = 33'sd16775851;
            7: v = 33'sd8388437;
            8: v = 33'sd4194283;
            9: v = 33'sd2097149;
            default:
            begin
                if (stage >= 30)
                begin
                    v = 33'sd1;
                end
                else
                begin
                    v = 33'sd1 <<< (30 - stage);
                end
            end
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/gcd_deg2rad.sv
// Three-stage degree (Q22) to radian (Q30) converter for a nonnegative angle.
module gcd_deg2rad #(
    parameter int SHIFT = 22
) (
    input  logic          clk,
    input  logic          en,
    input  gcd_pkg::deg_t ang,
    output gcd_pkg::rad_t rad
);
    import gcd_pkg::*;

    logic [54:0] pa_reg, pa2_reg;
    logic [32:0] u_reg;
    logic [59:0] pq_reg;
    logic [27:0] f_reg;
    rad_t        rad_reg;

    logic [33:0] u_full;
    logic [27:0] qhat;
    logic [32:0] rem_full;
    logic [7:0]  rem;
    logic [27:0] f_next;
    logic [54:0] sum;

    // floor(13*ang/90) via reciprocal of 45 on ang*13/2
    assign u_full   = 34'(ang) * 34'd13;
    assign qhat     = pq_reg[59:32];
    assign rem_full = u_reg - 33'(qhat) * 33'd45;
    assign rem      = rem_full[7:0];

    always_comb
    begin
        f_next = qhat;
        priority if (rem >= 8'd90)
        begin
            f_next = qhat + 28'd2;
        end
        else if (rem >= 8'd45)
        begin
            f_next = qhat + 28'd1;
        end
        else
        begin
            f_next = qhat;
        end
    end

    assign sum = pa2_reg + 55'(f_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg  <= 55'(ang) * 55'(PI_DIV_180);
            u_reg   <= u_full[33:1];
            pq_reg  <= 60'(u_full[33:1]) * 60'(RECIP_45);
            pa2_reg <= pa_reg;
            f_reg   <= f_next;
            rad_reg <= rad_t'(sum >> SHIFT);
        end
    end

    assign rad = rad_reg;

endmodule

// File: hw/rtl/gcd_cordic_cell.sv
// One CORDIC micro-rotation stage, rotation or vectoring mode.
module gcd_cordic_cell #(
    parameter int STAGE  = 0,
    parameter bit VECTOR = 1'b0
) (
    input  logic          clk,
    input  logic          en,
    input  gcd_pkg::cxy_t x_in,
    input  gcd_pkg::cxy_t y_in,
    input  gcd_pkg::cz_t  z_in,
    output gcd_pkg::cxy_t x_out,
    output gcd_pkg::cxy_t y_out,
    output gcd_pkg::cz_t  z_out
);
    import gcd_pkg::*;

    localparam cz_t ANGLE = atan_q30(STAGE);

    cxy_t x_reg, y_reg;
    cz_t  z_reg;
    cxy_t dx, dy;
    logic pos;

    assign dx  = y_in >>> STAGE;
    assign dy  = x_in >>> STAGE;
    // rotation steers on residual angle, vectoring drives y toward zero
    assign pos = VECTOR ? y_in[33] : !z_in[32];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (pos)
            begin
                x_reg <= x_in - dx;
                y_reg <= y_in + dy;
                z_reg <= z_in - ANGLE;
            end
            else
            begin
                x_reg <= x_in + dx;
                y_reg <= y_in - dy;
                z_reg <= z_in + ANGLE;
            end
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

// File: hw/rtl/gcd_sqrt_cell.sv
// One digit step of the restoring integer square root.
module gcd_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic         clk,
    input  logic         en,
    input  gcd_pkg::sq_t v_in,
    input  gcd_pkg::sq_t r_in,
    output gcd_pkg::sq_t v_out,
    output gcd_pkg::sq_t r_out
);
    import gcd_pkg::*;

    localparam sq_t BIT = sq_t'(1) << (2 * STEP);

    sq_t v_reg, r_reg;
    sq_t trial;

    assign trial = r_in + BIT;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (v_in >= trial)
            begin
                v_reg <= v_in - trial;
                r_reg <= (r_in >> 1) + BIT;
            end
            else
            begin
                v_reg <= v_in;
                r_reg <= r_in >> 1;
            end
        end
    end

    assign v_out = v_reg;
    assign r_out = r_reg;

endmodule

// File: hw/rtl/great_circle_distance.sv
// Top level: pipelined haversine great-circle distance between two points.
//
// Input stream s_*: one request per cycle carries two points (latitude and
// longitude, degrees scaled by 2^22). Output stream m_*: the distance in
// units of 1/256 km. Config channel cfg_*: sphere radius in whole km, always
// ready; write it only while the pipeline is empty.
//
// Pipeline order: sign handling and angle wrap, a 3-stage degree-to-radian
// converter, ITERATIONS sine/cosine CORDIC cells, three product stages, 31
// square-root cells, ITERATIONS arctangent CORDIC cells, the radius multiply
// and the output register. Throughput is one request per cycle while the
// receiver does not stall; every cell hands its result to the next one each
// cycle that the pipeline advances.
//
// Reset clears all valid bits and loads the radius with 6371 km. When the
// receiver stalls with a result pending, the whole pipeline holds and
// s_tready drops in the same cycle.
module great_circle_distance #(
    parameter int ITERATIONS = gcd_pkg::ITERATIONS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_latitude[29:0], first_longitude[60:30], second_latitude[90:61],
    // second_longitude[121:91], zero fill above
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // distance[22:0], zero fill above
    output logic [23:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [12:0]  cfg_data
);
    import gcd_pkg::*;

    localparam int LAT = 1 + CONV_STAGES + ITERATIONS + 3 + SQRT_STEPS + ITERATIONS + 2;
    localparam int FLAG_DEPTH = 1 + CONV_STAGES + ITERATIONS;

    logic [LAT-1:0] vld_reg;
    logic [12:0]    radius_reg;
    logic           advance;

    // ---------------- input wrap and fold ----------------
    logic signed [29:0] lat1, lat2;
    logic signed [30:0] lng1, lng2;
    logic signed [32:0] dlat, dlng, alat1, alat2;
    deg_t               ang_next [4];
    logic [1:0]         neg_next;

    deg_t       ang_reg   [4];
    logic [1:0] flags_reg [FLAG_DEPTH];

    function automatic deg_t wrap_abs(input logic signed [32:0] d);
        logic signed [32:0] w;
        w = d;
        priority if (w > HALF_TURN)
        begin
            w = w - FULL_TURN;
        end
        else if (w < -HALF_TURN)
        begin
            w = w + FULL_TURN;
        end
        else
        begin
            w = d;
        end
        if (w < 0)
        begin
            w = -w;
        end
        return deg_t'(w);
    endfunction

    function automatic logic [30:0] fold_cos(input logic signed [32:0] a);
        logic signed [32:0] m;
        logic               neg;
        m   = (a < 0) ? -a : a;
        neg = 1'b0;
        if (m > QUARTER_TURN)
        begin
            m   = HALF_TURN - m;
            neg = 1'b1;
        end
        return {neg, m[29:0]};
    endfunction

    logic [30:0] fold1, fold2;

    assign lat1 = s_tdata[29:0];
    assign lng1 = s_tdata[60:30];
    assign lat2 = s_tdata[90:61];
    assign lng2 = s_tdata[121:91];

    assign dlat  = 33'(lat2) - 33'(lat1);
    assign dlng  = 33'(lng2) - 33'(lng1);
    assign alat1 = 33'(lat1);
    assign alat2 = 33'(lat2);
    assign fold1 = fold_cos(alat1);
    assign fold2 = fold_cos(alat2);

    assign ang_next[0] = wrap_abs(dlat);
    assign ang_next[1] = wrap_abs(dlng);
    assign ang_next[2] = fold1[29:0];
    assign ang_next[3] = fold2[29:0];
    assign neg_next    = {fold2[30], fold1[30]};

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 4; i++)
            begin
                ang_reg[i] <= ang_next[i];
            end
            flags_reg[0] <= neg_next;
            for (int i = 1; i < FLAG_DEPTH; i++)
            begin
                flags_reg[i] <= flags_reg[i-1];
            end
        end
    end

    // ---------------- radians and sine/cosine lanes ----------------
    rad_t rad [4];
    cxy_t rot_x [4][ITERATIONS+1];
    cxy_t rot_y [4][ITERATIONS+1];
    cz_t  rot_z [4][ITERATIONS+1];

    for (genvar l = 0; l < 4; l++)
    begin : g_lane
        gcd_deg2rad #(
            .SHIFT ((l < 2) ? 23 : 22)
        ) u_conv (
            .clk (clk),
            .en  (advance),
            .ang (ang_reg[l]),
            .rad (rad[l])
        );

        assign rot_x[l][0] = CORDIC_GAIN;
        assign rot_y[l][0] = '0;
        assign rot_z[l][0] = cz_t'({2'b00, rad[l]});

        for (genvar s = 0; s < ITERATIONS; s++)
        begin : g_rot
            gcd_cordic_cell #(
                .STAGE  (s),
                .VECTOR (1'b0)
            ) u_cell (
                .clk   (clk),
                .en    (advance),
                .x_in  (rot_x[l][s]),
                .y_in  (rot_y[l][s]),
                .z_in  (rot_z[l][s]),
                .x_out (rot_x[l][s+1]),
                .y_out (rot_y[l][s+1]),
                .z_out (rot_z[l][s+1])
            );
        end
    end

    // ---------------- haversine term ----------------
    logic [1:0]         flags_end;
    cxy_t               c1n, c2n;
    logic signed [67:0] p_lat, p_lng, p_cos, p_cross;
    cxy_t               sq_lat_reg, sq_lng_reg, cos_prod_reg;
    cxy_t               sq_lat2_reg, cross_reg;
    logic signed [34:0] hav_sum;
    rad_t               hav_reg;

    assign flags_end = flags_reg[FLAG_DEPTH-1];
    assign c1n       = flags_end[0] ? -rot_x[2][ITERATIONS] : rot_x[2][ITERATIONS];
    assign c2n       = flags_end[1] ? -rot_x[3][ITERATIONS] : rot_x[3][ITERATIONS];
    assign p_lat     = rot_y[0][ITERATIONS] * rot_y[0][ITERATIONS];
    assign p_lng     = rot_y[1][ITERATIONS] * rot_y[1][ITERATIONS];
    assign p_cos     = c1n * c2n;
    assign p_cross   = cos_prod_reg * sq_lng_reg;
    assign hav_sum   = 35'(sq_lat2_reg) + 35'(cross_reg);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sq_lat_reg   <= cxy_t'(p_lat >>> 30);
            sq_lng_reg   <= cxy_t'(p_lng >>> 30);
            cos_prod_reg <= cxy_t'(p_cos >>> 30);
            sq_lat2_reg  <= sq_lat_reg;
            cross_reg    <= cxy_t'(p_cross >>> 30);
            // clamp a to [0, 1] so that neither a nor 1 - a goes negative
            priority if (hav_sum < 0)
            begin
                hav_reg <= '0;
            end
            else if (hav_sum > 35'(ONE_Q30))
            begin
                hav_reg <= ONE_Q30;
            end
            else
            begin
                hav_reg <= hav_sum[30:0];
            end
        end
    end

    // ---------------- square roots of a and 1-a ----------------
    sq_t sq_v [2][SQRT_STEPS+1];
    sq_t sq_r [2][SQRT_STEPS+1];
    rad_t one_minus;

    assign one_minus  = ONE_Q30 - hav_reg;
    assign sq_v[0][0] = {1'b0, hav_reg, 30'b0};
    assign sq_v[1][0] = {1'b0, one_minus, 30'b0};
    assign sq_r[0][0] = '0;
    assign sq_r[1][0] = '0;

    for (genvar l = 0; l < 2; l++)
    begin : g_root
        for (genvar s = 0; s < SQRT_STEPS; s++)
        begin : g_step
            gcd_sqrt_cell #(
                .STEP (SQRT_STEPS - 1 - s)
            ) u_cell (
                .clk   (clk),
                .en    (advance),
                .v_in  (sq_v[l][s]),
                .r_in  (sq_r[l][s]),
                .v_out (sq_v[l][s+1]),
                .r_out (sq_r[l][s+1])
            );
        end
    end

    // ---------------- arctangent ----------------
    cxy_t vec_x [ITERATIONS+1];
    cxy_t vec_y [ITERATIONS+1];
    cz_t  vec_z [ITERATIONS+1];

    assign vec_x[0] = cxy_t'({3'b000, sq_r[1][SQRT_STEPS][30:0]});
    assign vec_y[0] = cxy_t'({3'b000, sq_r[0][SQRT_STEPS][30:0]});
    assign vec_z[0] = '0;

    for (genvar s = 0; s < ITERATIONS; s++)
    begin : g_vec
        gcd_cordic_cell #(
            .STAGE  (s),
            .VECTOR (1'b1)
        ) u_cell (
            .clk   (clk),
            .en    (advance),
            .x_in  (vec_x[s]),
            .y_in  (vec_y[s]),
            .z_in  (vec_z[s]),
            .x_out (vec_x[s+1]),
            .y_out (vec_y[s+1]),
            .z_out (vec_z[s+1])
        );
    end

    // ---------------- scale by radius ----------------
    cz_t         z_end;
    rad_t        z_clamp;
    logic [43:0] scaled_reg;
    logic [44:0] rounded;
    logic [22:0] dist_reg;

    assign z_end = vec_z[ITERATIONS];

    always_comb
    begin
        priority if (z_end < 0)
        begin
            z_clamp = '0;
        end
        else if (z_end > cz_t'({2'b00, HALF_PI}))
        begin
            z_clamp = HALF_PI;
        end
        else
        begin
            z_clamp = z_end[30:0];
        end
    end

    assign rounded = {1'b0, scaled_reg} + (45'd1 << 20);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            scaled_reg <= 44'(radius_reg) * 44'(z_clamp);
            if (rounded[44:21] > 24'(MAX_DISTANCE))
            begin
                dist_reg <= MAX_DISTANCE;
            end
            else
            begin
                dist_reg <= rounded[43:21];
            end
        end
    end

    // ---------------- control ----------------
    assign advance   = !vld_reg[LAT-1] || m_tready;
    assign s_tready  = advance;
    assign m_tvalid  = vld_reg[LAT-1];
    assign m_tdata   = {1'b0, dist_reg};
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            radius_reg <= RADIUS_RESET;
        end
        else
        begin
            if (advance)
            begin
                vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
            end
            if (cfg_valid)
            begin
                radius_reg <= cfg_data;
            end
        end
    end

endmodule

// File: hw/rtl/gcd_checker.sv
// Port-level checks for the distance pipeline, bound to the top level.
module gcd_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [127:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [23:0]  m_tdata,
    input logic         cfg_valid,
    input logic         cfg_ready,
    input logic [12:0]  cfg_data
);
    import gcd_pkg::*;

    // hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // accept input exactly when the pipeline can advance
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[22:0] <= MAX_DISTANCE) && !m_tdata[23])
        else $error("distance out of range");

    a_reset: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

endmodule

bind great_circle_distance gcd_checker u_gcd_checker (.*);
